[design/ggns_pkg.sv]
`timescale 1ns / 1ps
package ggns_pkg;

  localparam int DEF_MAX_NX = 64;
  localparam int DEF_MAX_NY = 64;
  localparam int DEF_MAX_NZ = 1024;

  localparam int SIZE_RESET = 64;

  localparam int SAMPLE_W = 16;
  localparam int NORM_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam int Q_W    = 15;
  localparam int Q_ONE  = 16384;
  localparam int MAG_W  = 17;
  localparam int GRAD_W = 18;
  localparam int SQ_W   = 34;
  localparam int SUM_W  = 36;
  localparam int NW     = 68;
  localparam int MUL_W  = 18;
  localparam int FRAC_SHIFT = 28;

  typedef enum logic [3:0] {
    ST_CFG_PLANE,
    ST_CFG_TOTAL,
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_NINIT,
    ST_NSTEP,
    ST_NDIFF,
    ST_NRND,
    ST_OUT
  } state_e;

endpackage

[design/ggns_ring.sv]
`timescale 1ns / 1ps
module ggns_ring #(
  parameter int DEPTH = 3 * ggns_pkg::DEF_MAX_NX * ggns_pkg::DEF_MAX_NY,
  parameter int AW    = $clog2(3 * ggns_pkg::DEF_MAX_NX * ggns_pkg::DEF_MAX_NY)
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [AW-1:0]                        waddr_i,
  input  logic signed [ggns_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]                        raddr_i,
  output logic signed [ggns_pkg::SAMPLE_W-1:0] rdata_o
);
  import ggns_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/grid_gradient_normal_stencil.sv]
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// in       | in_valid_i / in_ready_o   | sample_i, drain_i
// out      | out_valid_o / out_ready_i | normal_x_o, normal_y_o, normal_z_o, last_cell_o
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item that yields no result is taken without leaving the idle state. An item that
// yields a cell runs the neighbour reads on the single ring read port, then gradient,
// squares and sum, then per axis the shared bit-serial normalizer (15 trial steps plus
// rounding). After reset and each register write, plane and grid size are recomputed.
// The result sits in an output register; the next item is taken while it waits.
module grid_gradient_normal_stencil
  import ggns_pkg::*;
#(
  parameter int MAX_NX = DEF_MAX_NX,
  parameter int MAX_NY = DEF_MAX_NY,
  parameter int MAX_NZ = DEF_MAX_NZ
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [ggns_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                   drain_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ggns_pkg::NORM_W-1:0]     normal_x_o,
  output logic signed [ggns_pkg::NORM_W-1:0]     normal_y_o,
  output logic signed [ggns_pkg::NORM_W-1:0]     normal_z_o,
  output logic                                   last_cell_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ggns_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ggns_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int SX_W = $clog2(MAX_NX + 1);
  localparam int SY_W = $clog2(MAX_NY + 1);
  localparam int SZ_W = $clog2(MAX_NZ + 1);
  localparam int IX_W = (MAX_NX > 1) ? $clog2(MAX_NX) : 1;
  localparam int IY_W = (MAX_NY > 1) ? $clog2(MAX_NY) : 1;
  localparam int IZ_W = (MAX_NZ > 1) ? $clog2(MAX_NZ) : 1;
  localparam int PLANE_MAX = MAX_NX * MAX_NY;
  localparam int TOTAL_MAX = PLANE_MAX * MAX_NZ;
  localparam int PL_W  = $clog2(PLANE_MAX + 1);
  localparam int CNT_W = $clog2(TOTAL_MAX + 1);
  localparam int DEPTH = 3 * PLANE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [SX_W-1:0] SX_RST = SX_W'((SIZE_RESET > MAX_NX) ? MAX_NX : SIZE_RESET);
  localparam logic [SY_W-1:0] SY_RST = SY_W'((SIZE_RESET > MAX_NY) ? MAX_NY : SIZE_RESET);
  localparam logic [SZ_W-1:0] SZ_RST = SZ_W'((SIZE_RESET > MAX_NZ) ? MAX_NZ : SIZE_RESET);

  state_e state_q, state_d;

  logic [SX_W-1:0] size_x_q;
  logic [SY_W-1:0] size_y_q;
  logic [SZ_W-1:0] size_z_q;
  logic [PL_W-1:0] plane_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] samples_q, cells_q;

  logic [IX_W-1:0] wi_q, ei_q;
  logic [IY_W-1:0] wj_q, ej_q;
  logic [IZ_W-1:0] ek_q;
  logic [1:0]      wp_q, ep_q;

  logic [2:0] rcnt_q;
  logic [1:0] ax_q;
  logic [3:0] bit_q;

  logic signed [SAMPLE_W-1:0] nb_q [6];
  logic signed [GRAD_W-1:0]   g_q [3];
  logic [MAG_W-1:0]           mag_q [3];
  logic [SQ_W-1:0]            sq_q [3];
  logic [SUM_W-1:0]           s_q;
  logic [NW-1:0]              t_q, p_q, qsh_q, ssh_q, dif_q;
  logic [Q_W-1:0]             q_q;
  logic signed [NORM_W-1:0]   res_q [3];

  logic                       out_valid_q, last_q;
  logic signed [NORM_W-1:0]   nx_q, ny_q, nz_q;

  // control outputs
  logic              ring_we;
  logic [AW-1:0]     ring_waddr, ring_raddr;
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  logic in_acc, cfg_acc, sample_acc, drain_emit, sample_emit, out_load;
  logic [CNT_W-1:0] samples_inc;
  logic [CNT_W-1:0] diff_cnt;

  // neighbor coordinates
  logic edge_x, edge_y, edge_z;
  logic [IX_W-1:0] i0, i1;
  logic [IY_W-1:0] j0, j1;
  logic [1:0] p0, p1;
  logic [NW-1:0] trial;
  logic [NW+1:0] rnd_lhs, rnd_rhs;
  logic rnd_up;
  logic [NORM_W-1:0] q_rnd;

  function automatic logic [AW-1:0] ring_addr(input logic [1:0] p, input logic [IY_W-1:0] j,
                                               input logic [IX_W-1:0] i);
    ring_addr = AW'(32'(p) * PLANE_MAX + 32'(j) * MAX_NX + 32'(i));
  endfunction

  ggns_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (sample_i),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign in_acc     = in_valid_i & in_ready_o;
  assign cfg_acc    = cfg_valid_i & cfg_ready_o;
  assign sample_acc = in_acc & ~drain_i & (samples_q < total_q);
  assign samples_inc = samples_q + CNT_W'(1);
  assign diff_cnt    = samples_inc - cells_q;
  assign drain_emit  = in_acc & drain_i & (samples_q == total_q) & (cells_q < total_q);
  assign sample_emit = sample_acc & (diff_cnt > CNT_W'(plane_q));
  assign out_load    = (state_q == ST_OUT) & (~out_valid_q | out_ready_i);

  assign edge_x = (ei_q == '0) || (ei_q == IX_W'(size_x_q - SX_W'(1)));
  assign edge_y = (ej_q == '0) || (ej_q == IY_W'(size_y_q - SY_W'(1)));
  assign edge_z = (ek_q == '0) || (ek_q == IZ_W'(size_z_q - SZ_W'(1)));
  assign i0 = (ei_q == '0) ? ei_q : ei_q - IX_W'(1);
  assign i1 = (ei_q == IX_W'(size_x_q - SX_W'(1))) ? ei_q : ei_q + IX_W'(1);
  assign j0 = (ej_q == '0) ? ej_q : ej_q - IY_W'(1);
  assign j1 = (ej_q == IY_W'(size_y_q - SY_W'(1))) ? ej_q : ej_q + IY_W'(1);
  assign p0 = (ek_q == '0) ? ep_q : ((ep_q == 2'd0) ? 2'd2 : ep_q - 2'd1);
  assign p1 = (ek_q == IZ_W'(size_z_q - SZ_W'(1))) ? ep_q :
              ((ep_q == 2'd2) ? 2'd0 : ep_q + 2'd1);

  assign mul_p = mul_a * mul_b;

  assign trial   = p_q + qsh_q + ssh_q;
  // round up when 4*(t - q^2 s) > 4*q*s + s
  assign rnd_lhs = {dif_q, 2'b00};
  assign rnd_rhs = {qsh_q, 2'b00} + (NW + 2)'(s_q);
  assign rnd_up  = (32'(q_q) < Q_ONE) && (rnd_lhs > rnd_rhs);
  assign q_rnd   = NORM_W'(q_q) + NORM_W'(rnd_up);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CFG_PLANE: state_d = ST_CFG_TOTAL;
      ST_CFG_TOTAL: state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_acc) begin
          state_d = ST_CFG_PLANE;
        end else if (drain_emit || sample_emit) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  if (rcnt_q == 3'd6) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQ;
      ST_SQ:    if (ax_q == 2'd2) state_d = ST_SUM;
      ST_SUM:   state_d = ST_NINIT;
      ST_NINIT: state_d = (s_q == '0) ? ST_OUT : ST_NSTEP;
      ST_NSTEP: if (bit_q == 4'd0) state_d = ST_NDIFF;
      ST_NDIFF: state_d = ST_NRND;
      ST_NRND:  state_d = (ax_q == 2'd2) ? ST_OUT : ST_NINIT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) & ~cfg_valid_i;
    cfg_ready_o = (state_q == ST_IDLE);
    ring_we     = sample_acc;
    ring_waddr  = ring_addr(wp_q, wj_q, wi_q);
    ring_raddr  = ring_addr(ep_q, ej_q, i0);
    mul_a       = MUL_W'(mag_q[ax_q]);
    mul_b       = MUL_W'(mag_q[ax_q]);
    unique case (rcnt_q)
      3'd0:    ring_raddr = ring_addr(ep_q, ej_q, i0);
      3'd1:    ring_raddr = ring_addr(ep_q, ej_q, i1);
      3'd2:    ring_raddr = ring_addr(ep_q, j0, ei_q);
      3'd3:    ring_raddr = ring_addr(ep_q, j1, ei_q);
      3'd4:    ring_raddr = ring_addr(p0, ej_q, ei_q);
      3'd5:    ring_raddr = ring_addr(p1, ej_q, ei_q);
      default: ring_raddr = ring_addr(ep_q, ej_q, ei_q);
    endcase
    unique case (state_q)
      ST_CFG_PLANE: begin
        mul_a = MUL_W'(size_x_q);
        mul_b = MUL_W'(size_y_q);
      end
      ST_CFG_TOTAL: begin
        mul_a = MUL_W'(plane_q);
        mul_b = MUL_W'(size_z_q);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CFG_PLANE;
      size_x_q    <= SX_RST;
      size_y_q    <= SY_RST;
      size_z_q    <= SZ_RST;
      samples_q   <= '0;
      cells_q     <= '0;
      wi_q        <= '0;
      wj_q        <= '0;
      wp_q        <= '0;
      ei_q        <= '0;
      ej_q        <= '0;
      ek_q        <= '0;
      ep_q        <= '0;
      rcnt_q      <= '0;
      ax_q        <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc && cfg_index_i <= CFG_SIZE_Z) begin
        unique case (cfg_index_i)
          CFG_SIZE_X: begin
            if (cfg_data_i[6:0] == '0) size_x_q <= SX_W'(1);
            else if (32'(cfg_data_i[6:0]) > MAX_NX) size_x_q <= SX_W'(MAX_NX);
            else size_x_q <= SX_W'(cfg_data_i[6:0]);
          end
          CFG_SIZE_Y: begin
            if (cfg_data_i[6:0] == '0) size_y_q <= SY_W'(1);
            else if (32'(cfg_data_i[6:0]) > MAX_NY) size_y_q <= SY_W'(MAX_NY);
            else size_y_q <= SY_W'(cfg_data_i[6:0]);
          end
          default: begin
            if (cfg_data_i == '0) size_z_q <= SZ_W'(1);
            else if (32'(cfg_data_i) > MAX_NZ) size_z_q <= SZ_W'(MAX_NZ);
            else size_z_q <= SZ_W'(cfg_data_i);
          end
        endcase
        samples_q <= '0;
        cells_q   <= '0;
        wi_q <= '0;
        wj_q <= '0;
        wp_q <= '0;
        ei_q <= '0;
        ej_q <= '0;
        ek_q <= '0;
        ep_q <= '0;
      end
      if (sample_acc) begin
        samples_q <= samples_inc;
        if (wi_q == IX_W'(size_x_q - SX_W'(1))) begin
          wi_q <= '0;
          if (wj_q == IY_W'(size_y_q - SY_W'(1))) begin
            wj_q <= '0;
            wp_q <= (wp_q == 2'd2) ? 2'd0 : wp_q + 2'd1;
          end else begin
            wj_q <= wj_q + IY_W'(1);
          end
        end else begin
          wi_q <= wi_q + IX_W'(1);
        end
      end
      if (state_q == ST_IDLE) begin
        rcnt_q <= '0;
        ax_q   <= '0;
      end
      if (state_q == ST_READ) rcnt_q <= rcnt_q + 3'd1;
      if (state_q == ST_SQ) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
      if (state_q == ST_NINIT) bit_q <= 4'(Q_W - 1);
      if (state_q == ST_NSTEP) bit_q <= bit_q - 4'd1;
      if (state_q == ST_NRND) ax_q <= ax_q + 2'd1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (cells_q + CNT_W'(1) >= total_q) begin
          samples_q <= '0;
          cells_q   <= '0;
          wi_q <= '0;
          wj_q <= '0;
          wp_q <= '0;
          ei_q <= '0;
          ej_q <= '0;
          ek_q <= '0;
          ep_q <= '0;
        end else begin
          cells_q <= cells_q + CNT_W'(1);
          if (ei_q == IX_W'(size_x_q - SX_W'(1))) begin
            ei_q <= '0;
            if (ej_q == IY_W'(size_y_q - SY_W'(1))) begin
              ej_q <= '0;
              ek_q <= ek_q + IZ_W'(1);
              ep_q <= (ep_q == 2'd2) ? 2'd0 : ep_q + 2'd1;
            end else begin
              ej_q <= ej_q + IY_W'(1);
            end
          end else begin
            ei_q <= ei_q + IX_W'(1);
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CFG_PLANE: plane_q <= PL_W'(mul_p);
      ST_CFG_TOTAL: total_q <= CNT_W'(mul_p);
      ST_READ: begin
        if (rcnt_q != 3'd0) nb_q[rcnt_q - 3'd1] <= ring_rdata;
      end
      ST_DIFF: begin
        for (int a = 0; a < 3; a++) begin
          logic signed [GRAD_W-1:0] d;
          logic e;
          d = GRAD_W'(nb_q[2*a+1]) - GRAD_W'(nb_q[2*a]);
          e = (a == 0) ? edge_x : ((a == 1) ? edge_y : edge_z);
          if (e) d = d <<< 1;
          g_q[a]   <= d;
          mag_q[a] <= d[GRAD_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
      end
      ST_SQ:  sq_q[ax_q] <= SQ_W'(mul_p);
      ST_SUM: s_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      ST_NINIT: begin
        t_q   <= NW'(sq_q[ax_q]) << FRAC_SHIFT;
        p_q   <= '0;
        qsh_q <= '0;
        ssh_q <= NW'(s_q) << FRAC_SHIFT;
        q_q   <= '0;
        if (s_q == '0) begin
          for (int a = 0; a < 3; a++) res_q[a] <= '0;
        end
      end
      ST_NSTEP: begin
        // qsh = q*s << (b+1), ssh = s << 2b
        if (trial <= t_q) begin
          p_q   <= trial;
          qsh_q <= (qsh_q >> 1) + ssh_q;
          q_q[bit_q] <= 1'b1;
        end else begin
          qsh_q <= qsh_q >> 1;
        end
        ssh_q <= ssh_q >> 2;
      end
      ST_NDIFF: dif_q <= t_q - p_q;
      ST_NRND: begin
        res_q[ax_q] <= g_q[ax_q][GRAD_W-1] ? NORM_W'(-q_rnd) : q_rnd;
      end
      ST_OUT: begin
        if (out_load) begin
          nx_q   <= res_q[0];
          ny_q   <= res_q[1];
          nz_q   <= res_q[2];
          last_q <= (cells_q == total_q - CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = nz_q;
  assign last_cell_o = last_q;

endmodule

[design/ggns_checker.sv]
`timescale 1ns / 1ps
module ggns_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic signed [ggns_pkg::SAMPLE_W-1:0] sample_i,
  input logic                                 drain_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [ggns_pkg::NORM_W-1:0]   normal_x_o,
  input logic signed [ggns_pkg::NORM_W-1:0]   normal_y_o,
  input logic signed [ggns_pkg::NORM_W-1:0]   normal_z_o,
  input logic                                 last_cell_o,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o,
  input logic [ggns_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input logic [ggns_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ggns_pkg::*;

  // a pending result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o)
      && $stable(normal_y_o) && $stable(normal_z_o) && $stable(last_cell_o))
    else $error("result beat changed while stalled");

  // sizes are recomputed after a register write, so no input is taken next cycle
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input taken right after register write");

  // a new result only comes out of the busy sequencer
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384
      && normal_y_o >= -16'sd16384 && normal_y_o <= 16'sd16384
      && normal_z_o >= -16'sd16384 && normal_z_o <= 16'sd16384)
    else $error("normal component out of Q1.14 unit range");

endmodule

bind grid_gradient_normal_stencil ggns_checker u_ggns_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import ggns_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       drn;
  } beat_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     last;
  } normal_t;

  logic clk, rst_n;
  logic in_valid, in_ready, drain;
  logic signed [SAMPLE_W-1:0] sample;
  logic out_valid, out_ready, last_cell;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_gradient_normal_stencil i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .sample_i(sample), .drain_i(drain),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .last_cell_o(last_cell),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic signed [15:0] plane_mem [0:3*DEF_MAX_NX*DEF_MAX_NY-1];
  int unsigned taken_cnt, emitted_cnt, gx_n, gy_n, gz_n;

  beat_t   pending_q[$];
  normal_t normal_q[$];
  int send_idle, recv_idle, errors, beats_in, hold_cnt;
  bit hold_done, in_took;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned mem_addr(int unsigned i, int unsigned j, int unsigned k);
    return ((k % 3) * DEF_MAX_NY + j) * DEF_MAX_NX + i;
  endfunction

  function automatic logic signed [15:0] unit_component(longint g, longint unsigned s);
    longint unsigned a, t, d, qs;
    int unsigned lo, hi, mid, q;
    a = (g < 0) ? -g : g;
    t = (a * a) << FRAC_SHIFT;
    lo = 0;
    hi = Q_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (longint'(mid) * mid * s <= t) lo = mid;
      else hi = mid - 1;
    end
    q = lo;
    d = t - longint'(q) * q * s;
    qs = longint'(q) * s;
    // round to nearest, ties toward zero
    if (q < Q_ONE && d > qs && 4 * (d - qs) > s) q++;
    return (g < 0) ? -$signed(16'(q)) : $signed(16'(q));
  endfunction

  function automatic normal_t cell_normal();
    int unsigned c, i, j, k, i0, i1, j0, j1, k0, k1, total;
    longint gx, gy, gz;
    longint unsigned s;
    normal_t r;
    c = emitted_cnt;
    total = gx_n * gy_n * gz_n;
    i = c % gx_n;
    j = (c / gx_n) % gy_n;
    k = c / (gx_n * gy_n);
    i0 = (i == 0) ? i : i - 1;
    i1 = (i == gx_n - 1) ? i : i + 1;
    j0 = (j == 0) ? j : j - 1;
    j1 = (j == gy_n - 1) ? j : j + 1;
    k0 = (k == 0) ? k : k - 1;
    k1 = (k == gz_n - 1) ? k : k + 1;
    // twice the gradient: edges use the one-sided difference, doubled
    gx = plane_mem[mem_addr(i1, j, k)] - plane_mem[mem_addr(i0, j, k)];
    gy = plane_mem[mem_addr(i, j1, k)] - plane_mem[mem_addr(i, j0, k)];
    gz = plane_mem[mem_addr(i, j, k1)] - plane_mem[mem_addr(i, j, k0)];
    if (i0 == i || i1 == i) gx = 2 * gx;
    if (j0 == j || j1 == j) gy = 2 * gy;
    if (k0 == k || k1 == k) gz = 2 * gz;
    s = gx * gx + gy * gy + gz * gz;
    r = '0;
    if (s != 0) begin
      r.nx = unit_component(gx, s);
      r.ny = unit_component(gy, s);
      r.nz = unit_component(gz, s);
    end
    r.last = (c == total - 1);
    emitted_cnt = c + 1;
    if (emitted_cnt >= total) begin
      emitted_cnt = 0;
      taken_cnt = 0;
    end
    return r;
  endfunction

  function automatic void predict_beat(beat_t b);
    int unsigned plane, total, s;
    plane = gx_n * gy_n;
    total = plane * gz_n;
    if (b.drn) begin
      if (taken_cnt == total && emitted_cnt < total) normal_q.push_back(cell_normal());
      return;
    end
    if (taken_cnt >= total) return;
    s = taken_cnt;
    plane_mem[mem_addr(s % gx_n, (s / gx_n) % gy_n, s / plane)] = b.smp;
    taken_cnt = s + 1;
    if (taken_cnt - emitted_cnt > plane) normal_q.push_back(cell_normal());
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_SIZE_X: gx_n = clamp_dim(v & 11'h7f, DEF_MAX_NX);
      CFG_SIZE_Y: gy_n = clamp_dim(v & 11'h7f, DEF_MAX_NY);
      CFG_SIZE_Z: gz_n = clamp_dim(v, DEF_MAX_NZ);
      default: return;
    endcase
    taken_cnt = 0;
    emitted_cnt = 0;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        sample   <= pending_q[0].smp;
        drain    <= pending_q[0].drn;
        void'(pending_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!hold_done && beats_in >= 500) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_t exp_n, got;
    in_took = in_valid && in_ready;
    if (in_took) begin
      beats_in++;
      predict_beat('{smp: sample, drn: drain});
    end
    if (out_valid && out_ready) begin
      got = '{nx: normal_x, ny: normal_y, nz: normal_z, last: last_cell};
      if (normal_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
      end else begin
        exp_n = normal_q.pop_front();
        if (got !== exp_n) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp_n, got);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || normal_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(int unsigned x, int unsigned y, int unsigned z);
    wait_drained();
    reg_write(CFG_SIZE_X, CFG_DATA_W'(x));
    reg_write(CFG_SIZE_Y, CFG_DATA_W'(y));
    reg_write(CFG_SIZE_Z, CFG_DATA_W'(z));
  endtask

  function automatic logic signed [15:0] field_value(int unsigned s);
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2:    return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'(s * 37)) + $signed(16'($urandom_range(15))) - 16'sd8;
    endcase
  endfunction

  // one grid of samples followed by its drains, with some noise mixed in;
  // a limit below the grid size leaves the grid unfinished
  task automatic fill_grid(int unsigned limit);
    int unsigned total, n;
    total = gx_n * gy_n * gz_n;
    n = (limit < total) ? limit : total;
    for (int unsigned s = 0; s < n; s++) begin
      if ($urandom_range(99) < 4) pending_q.push_back('{smp: 16'($urandom), drn: 1'b1});
      pending_q.push_back('{smp: field_value(s), drn: 1'b0});
    end
    if (n < total) return;
    if ($urandom_range(3) == 0) pending_q.push_back('{smp: 16'($urandom), drn: 1'b0});
    for (int unsigned d = 0; d < gx_n * gy_n; d++)
      pending_q.push_back('{smp: 16'($urandom), drn: 1'b1});
    if ($urandom_range(3) == 0) pending_q.push_back('{smp: 16'($urandom), drn: 1'b1});
  endtask

  task automatic random_grids(int unsigned beats);
    int unsigned start;
    start = beats_in;
    while (beats_in - start < beats) begin
      set_grid($urandom_range(6, 1), $urandom_range(5, 1), $urandom_range(5, 1));
      fill_grid(1000);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    drain = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SIZE_X;
    cfg_data = '0;
    errors = 0;
    beats_in = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    in_took = 1'b0;
    taken_cnt = 0;
    emitted_cnt = 0;
    gx_n = SIZE_RESET;
    gy_n = SIZE_RESET;
    gz_n = SIZE_RESET;
    send_idle = 37;
    recv_idle = 68;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 3x2x2 grid with extreme samples and the odd drains
    set_grid(3, 2, 2);
    pending_q.push_back('{smp: 16'sh0000, drn: 1'b1});   // nothing pending
    pending_q.push_back('{smp: 16'sh8000, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh7fff, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh0000, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh7fff, drn: 1'b1});   // drain with sample: ignored sample
    pending_q.push_back('{smp: 16'sh7fff, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh8000, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh0005, drn: 1'b0});
    for (int n = 0; n < 6; n++) pending_q.push_back('{smp: 16'sh0005, drn: 1'b0});
    pending_q.push_back('{smp: 16'sh1234, drn: 1'b0});   // grid full: ignored
    for (int n = 0; n < 7; n++) pending_q.push_back('{smp: 16'shffff, drn: 1'b1});
    // flat field: zero gradient everywhere; x of size one
    set_grid(1, 2, 2);
    for (int n = 0; n < 4; n++) pending_q.push_back('{smp: 16'sh0100, drn: 1'b0});
    for (int n = 0; n < 2; n++) pending_q.push_back('{smp: 16'sh0000, drn: 1'b1});
    // clamped sizes: 0 -> 1, 127 -> 64
    set_grid(0, 127, 2);
    fill_grid(1000);
    random_grids(60);

    send_idle = 68;
    recv_idle = 37;
    set_grid(127, 1, 0);
    fill_grid(1000);
    random_grids(100);

    send_idle = 0;
    recv_idle = 0;
    set_grid(1, 1, 2047);
    fill_grid(40);                     // deep z, left unfinished
    wait_drained();
    reg_write(2'd3, 11'h7ff);          // unmapped index
    set_grid(64, 64, 1024);
    fill_grid(30);
    random_grids(120);
    wait_drained();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
